/* sv/lsip_pkg.sv */
// Shared types and codes for the LIFO stack with indexed peek.
// No dependencies; used by the top level, the controller and the checker.
`default_nettype none

package lsip_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH      = 3'd0,
    REQ_POP       = 3'd1,
    REQ_POP_N     = 3'd2,
    REQ_PEEK_TOP  = 3'd3,
    REQ_PEEK_BOT  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] push_value;
    logic [7:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [7:0]         entry_count;
  } out_item_t;

  // Decoded access for one item, from the controller to the datapath.
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    status_e status;
  } op_t;

endpackage

`default_nettype wire

/* sv/lifo_stack_with_indexed_peek.sv */
// Top level of the LIFO stack with indexed peek: controller, entry store,
// read stage and output register. Depends on lsip_pkg, lsip_ctrl, lsip_mem.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+--------------------------
//   input   | in_valid_i | in_stall_o  | in_item_i  (in_item_t)
//   output  | out_valid_o| out_stall_i | out_item_o (out_item_t)
//
// One item per cycle while in_stall_o is low; each accepted item passes the read
// stage, then the output register, on its way to out_valid_o. The memory is accessed
// at the accept edge; its registered read data goes on to the output register. Each
// item makes at most one access. Reset empties the stack; the store itself is not cleared.
// With the output stalled, one more item is taken into the read stage, then
// in_stall_o rises.
`default_nettype none

module lifo_stack_with_indexed_peek #(
  parameter int DEPTH = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire lsip_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output lsip_pkg::out_item_t     out_item_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic               accept, adv;
  lsip_pkg::op_t      op;
  logic [AW-1:0]      addr;
  logic [CW-1:0]      count_d;
  logic [31:0]        rdata;

  logic               s1_valid_q, s1_valid_d;
  logic               s1_rd_q;
  lsip_pkg::status_e  s1_status_q;
  logic [7:0]         s1_count_q;

  logic               out_valid_q, out_valid_d;
  lsip_pkg::out_item_t out_item_q, out_item_d;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  lsip_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_item_i),
    .op_o     (op),
    .addr_o   (addr),
    .count_o  (count_d)
  );

  lsip_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .wr_en_i (accept && op.wr_en),
    .rd_en_i (accept && op.rd_en),
    .addr_i  (addr),
    .wdata_i (in_item_i.push_value),
    .rdata_o (rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (adv) begin
      out_valid_d             = s1_valid_q;
      out_item_d.read_value   = s1_rd_q ? rdata : '0;
      out_item_d.status       = s1_status_q;
      out_item_d.entry_count  = s1_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q     <= op.rd_en;
      s1_status_q <= op.status;
      s1_count_q  <= 8'(count_d);
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

/* sv/lsip_mem.sv */
// Entry store: one synchronous single-port memory, read data registered.
// Depends on nothing but its parameters.
`default_nettype none

module lsip_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [31:0]   wdata_i,
  output logic      [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (rd_en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/lsip_ctrl.sv */
// Request decode and fill count: picks the memory address, status and new count.
// Depends on lsip_pkg.
`default_nettype none

module lsip_ctrl #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int CW    = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire lsip_pkg::in_item_t req_i,
  output lsip_pkg::op_t          op_o,
  output logic [AW-1:0]          addr_o,
  output logic [CW-1:0]          count_o
);

  // compare width covers both the count and the 8-bit position
  localparam int EW = (CW > 8) ? CW : 8;

  logic [CW-1:0] count_q, count_d;
  logic [EW-1:0] count_x, n_x, depth_x, diff_x, nm1_x, cm1_x;
  logic          n_zero, n_over;

  assign count_x = EW'(count_q);
  assign n_x     = EW'(req_i.position);
  assign depth_x = EW'(DEPTH);
  assign diff_x  = count_x - n_x;
  assign nm1_x   = n_x - EW'(1);
  assign cm1_x   = count_x - EW'(1);
  assign n_zero  = (n_x == '0);
  assign n_over  = (n_x > count_x);

  always_comb begin
    op_o.wr_en  = 1'b0;
    op_o.rd_en  = 1'b0;
    op_o.status = lsip_pkg::ST_OK;
    addr_o      = count_q[AW-1:0];
    count_d     = count_q;
    case (lsip_pkg::req_e'(req_i.req_type))
      lsip_pkg::REQ_PUSH: begin
        if (count_x == depth_x) begin
          op_o.status = lsip_pkg::ST_OVERFLOW;
        end else begin
          op_o.wr_en = 1'b1;
          count_d    = count_q + CW'(1);
        end
      end
      lsip_pkg::REQ_POP: begin
        if (count_x == '0) begin
          op_o.status = lsip_pkg::ST_UNDERFLOW;
        end else begin
          op_o.rd_en = 1'b1;
          addr_o     = cm1_x[AW-1:0];
          count_d    = cm1_x[CW-1:0];
        end
      end
      lsip_pkg::REQ_POP_N: begin
        if (n_over) begin
          op_o.status = lsip_pkg::ST_UNDERFLOW;
          count_d     = '0;
        end else if (!n_zero) begin
          // deepest removed entry is the one returned
          op_o.rd_en = 1'b1;
          addr_o     = diff_x[AW-1:0];
          count_d    = diff_x[CW-1:0];
        end
      end
      lsip_pkg::REQ_PEEK_TOP: begin
        if (n_zero || n_over) begin
          op_o.status = lsip_pkg::ST_RANGE;
        end else begin
          op_o.rd_en = 1'b1;
          addr_o     = diff_x[AW-1:0];
        end
      end
      lsip_pkg::REQ_PEEK_BOT: begin
        if (n_zero || n_over) begin
          op_o.status = lsip_pkg::ST_RANGE;
        end else begin
          op_o.rd_en = 1'b1;
          addr_o     = nm1_x[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_d;

endmodule

`default_nettype wire

/* sv/lsip_checker.sv */
// Port-level checks for the LIFO stack with indexed peek, bound to the top.
// Depends on lsip_pkg and lifo_stack_with_indexed_peek.
`default_nettype none

module lsip_checker #(
  parameter int DEPTH = 128
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire lsip_pkg::out_item_t out_item_o
);

  // a stalled result item stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // input backs up only behind a stalled, full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != lsip_pkg::ST_OK |-> out_item_o.read_value == '0)
    else $error("error status with nonzero data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == lsip_pkg::ST_UNDERFLOW
      |-> out_item_o.entry_count == '0)
    else $error("underflow left entries behind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == lsip_pkg::ST_OVERFLOW
      |-> out_item_o.entry_count == 8'(DEPTH))
    else $error("overflow reported below full");

endmodule

bind lifo_stack_with_indexed_peek lsip_checker #(.DEPTH(DEPTH)) u_lsip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
